// ===== rtl/alr_pkg.sv =====
// shared types, codes and helpers for the looper core
// no dependencies
package alr_pkg;

    localparam int POS_W = 17;
    localparam int SMP_W = 18;
    localparam int MIX_W = 19;
    localparam int STO_W = 16;

    localparam logic [2:0] FUNC_SAMPLE  = 3'd0;
    localparam logic [2:0] FUNC_REC     = 3'd1;
    localparam logic [2:0] FUNC_CLOSE   = 3'd2;
    localparam logic [2:0] FUNC_OVD_ON  = 3'd3;
    localparam logic [2:0] FUNC_OVD_OFF = 3'd4;
    localparam logic [2:0] FUNC_CLEAR   = 3'd5;

    localparam logic [1:0] MODE_EMPTY = 2'd0;
    localparam logic [1:0] MODE_REC   = 2'd1;
    localparam logic [1:0] MODE_PLAY  = 2'd2;
    localparam logic [1:0] MODE_OVD   = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]        len;
        logic [POS_W-1:0]        pos;
        logic [1:0]              mode;
        logic signed [MIX_W-1:0] mixed;
    } t_result;

    // clip to +-1.0 and scale by 32767/32768, truncating toward zero
    function automatic logic signed [STO_W-1:0] f_to_store(input logic signed [MIX_W-1:0] x);
        logic signed [MIX_W-1:0] c;
        logic signed [MIX_W-1:0] d;
        c = x;
        if (x > 19'sd32768) begin
            c = 19'sd32768;
        end else if (x < -19'sd32768) begin
            c = -19'sd32768;
        end
        if (c > 19'sd0) begin
            d = c - 19'sd1;
        end else if (c < 19'sd0) begin
            d = c + 19'sd1;
        end else begin
            d = 19'sd0;
        end
        return d[STO_W-1:0];
    endfunction

endpackage

// ===== rtl/audio_looper_record_overdub_core.sv =====
// Looper core taking one word per clock unless the output is stalled: each word is
// processed in the cycle it is accepted and its result lands in an output register,
// so the sustained rate is one item per cycle while i_m_tready holds. The store read
// is registered and addressed with the next play position, with same-cycle write
// data forwarded, so overdub read-modify-write needs no stall. The store needs no
// clearing after reset. Uses alr_pkg, alr_ctrl and alr_store.
module audio_looper_record_overdub_core #(
    parameter int STORE_DEPTH = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,      // loop_capacity
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,       // live_sample[17:0], zero pad
    input  logic [2:0]  i_s_tuser,       // func[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata        // mixed_sample, looper_mode, play_position,
                                         // loop_length, zero pad
);
    import alr_pkg::*;

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic                    accept;
    logic                    cfg_we;
    t_result                 result;
    t_result                 r_out;
    logic                    r_out_valid;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           raddr;
    logic signed [STO_W-1:0] wdata;
    logic signed [STO_W-1:0] rdata;

    assign o_cfg_ready = i_rst_n;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_s_tready  = i_rst_n && (!r_out_valid || i_m_tready);
    assign accept      = i_s_tvalid && o_s_tready;

    alr_ctrl #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_func     (i_s_tuser),
        .i_live     (i_s_tdata[SMP_W-1:0]),
        .i_old      (rdata),
        .o_result   (result),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr)
    );

    alr_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.len, r_out.pos, r_out.mode, r_out.mixed};

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_tvalid)
        else $error("accepted word produced no result");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_tready)
        else $error("input stalled with empty output register");

    a_out_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out.pos <= r_out.len))
        else $error("reported position beyond loop length");
`endif

endmodule

// ===== rtl/alr_store.sv =====
// loop sample memory, one write and one registered read per cycle
// write data is forwarded to a read of the same address in the same cycle
module alr_store #(
    parameter int STORE_DEPTH = 65536,
    parameter int AW          = 16
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic signed [15:0]      i_wdata,
    input  logic [AW-1:0]           i_raddr,
    output logic signed [15:0]      o_rdata
);

    logic signed [15:0] r_mem [STORE_DEPTH];
    logic signed [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/alr_ctrl.sv =====
// looper state: mode, position, length, capacity register and the mix path
// uses alr_pkg; drives the store write port and the look-ahead read address
module alr_ctrl #(
    parameter int STORE_DEPTH = 65536,
    parameter int AW          = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [alr_pkg::POS_W-1:0]       i_cfg_data,
    input  logic                            i_accept,
    input  logic [2:0]                      i_func,
    input  logic signed [alr_pkg::SMP_W-1:0] i_live,
    input  logic signed [alr_pkg::STO_W-1:0] i_old,
    output alr_pkg::t_result                o_result,
    output logic                            o_we,
    output logic [AW-1:0]                   o_waddr,
    output logic signed [alr_pkg::STO_W-1:0] o_wdata,
    output logic [AW-1:0]                   o_raddr
);
    import alr_pkg::*;

    localparam logic [31:0]      DEPTH32 = 32'(STORE_DEPTH);
    localparam logic [POS_W-1:0] DEPTH17 = POS_W'(STORE_DEPTH);

    logic [POS_W-1:0] r_cap, n_cap;
    logic [1:0]       r_mode, n_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_len, n_len;

    logic [POS_W-1:0]        cap_eff;
    logic                    pos_in_store;
    logic signed [MIX_W-1:0] live_ext;
    logic signed [MIX_W-1:0] old_ext;
    logic signed [MIX_W-1:0] sum;
    logic signed [MIX_W-1:0] mixed;
    logic [POS_W-1:0]        pos_inc;
    logic                    we;
    logic signed [STO_W-1:0] wdata;
    logic [POS_W+AW-1:0]     waddr_ext;
    logic [POS_W+AW-1:0]     raddr_ext;

    always_comb begin
        if ({15'd0, r_cap} > DEPTH32) begin
            cap_eff = DEPTH17;
        end else begin
            cap_eff = r_cap;
        end
        pos_in_store = ({15'd0, r_pos} < DEPTH32);
        live_ext     = {i_live[SMP_W-1], i_live};
        old_ext      = {{(MIX_W-STO_W){i_old[STO_W-1]}}, i_old};
        sum          = live_ext + old_ext;
        pos_inc      = r_pos + 17'd1;

        n_cap  = r_cap;
        n_mode = r_mode;
        n_pos  = r_pos;
        n_len  = r_len;
        mixed  = '0;
        we     = 1'b0;
        wdata  = f_to_store(live_ext);

        case (i_func)
            FUNC_SAMPLE: begin
                mixed = live_ext;
                if (cap_eff != '0) begin
                    if (r_mode == MODE_REC) begin
                        if ((r_pos < cap_eff) && pos_in_store) begin
                            we    = 1'b1;
                            n_pos = pos_inc;
                            n_len = pos_inc;
                        end else begin
                            n_len  = r_pos;
                            n_pos  = '0;
                            n_mode = MODE_PLAY;
                        end
                    end else if ((r_mode inside {MODE_PLAY, MODE_OVD}) && (r_len != '0)) begin
                        if (pos_in_store) begin
                            if (r_mode == MODE_OVD) begin
                                we    = 1'b1;
                                wdata = f_to_store(sum);
                            end
                            mixed = sum;
                        end
                        n_pos = (pos_inc >= r_len) ? '0 : pos_inc;
                    end
                end
            end
            FUNC_REC: begin
                if (cap_eff != '0) begin
                    n_pos  = '0;
                    n_len  = '0;
                    n_mode = MODE_REC;
                end
            end
            FUNC_CLOSE: begin
                if (r_mode == MODE_REC) begin
                    n_len  = r_pos;
                    n_pos  = '0;
                    n_mode = (r_pos != '0) ? MODE_PLAY : MODE_EMPTY;
                end
            end
            FUNC_OVD_ON: begin
                if (r_len != '0) begin
                    n_mode = MODE_OVD;
                end
            end
            FUNC_OVD_OFF: begin
                if (r_len != '0) begin
                    n_mode = MODE_PLAY;
                end
            end
            FUNC_CLEAR: begin
                n_mode = MODE_EMPTY;
                n_len  = '0;
                n_pos  = '0;
            end
            default: begin
            end
        endcase

        o_result.mixed = mixed;
        o_result.mode  = n_mode;
        o_result.pos   = n_pos;
        o_result.len   = n_len;

        if (!i_accept) begin
            n_mode = r_mode;
            n_pos  = r_pos;
            n_len  = r_len;
            we     = 1'b0;
        end
        if (i_cfg_we) begin
            n_cap  = i_cfg_data;
            n_mode = MODE_EMPTY;
            n_pos  = '0;
            n_len  = '0;
            we     = 1'b0;
        end
    end

    // store index from the position, zero extended when the store is deeper
    assign waddr_ext = {{AW{1'b0}}, r_pos};
    assign raddr_ext = {{AW{1'b0}}, n_pos};
    assign o_waddr   = waddr_ext[AW-1:0];
    assign o_raddr   = raddr_ext[AW-1:0];
    assign o_we      = we;
    assign o_wdata   = wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= '0;
            r_mode <= MODE_EMPTY;
            r_pos  <= '0;
            r_len  <= '0;
        end else begin
            r_cap  <= n_cap;
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_len  <= n_len;
        end
    end

`ifndef SYNTHESIS
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_mode == MODE_EMPTY && r_pos == '0 && r_len == '0))
        else $error("config write did not clear looper state");

    a_pos_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_len)
        else $error("position beyond loop length");

    a_rec_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_REC) |-> (r_pos <= cap_eff))
        else $error("recording position beyond capacity");

    a_we_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (i_accept && (r_mode == MODE_REC || r_mode == MODE_OVD)))
        else $error("store write outside record or overdub");
`endif

endmodule
